>>> src/w3c_pkg.sv
package w3c_pkg;

  // defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 16;
  localparam int COEF_BITS_DEF  = 8;

  // fixed field and register widths
  localparam int FILTERED_BITS   = 23;
  localparam int COLUMN_BITS     = 10;
  localparam int ROW_BITS        = 12;
  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int CFG_INDEX_BITS  = 3;

  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 4096;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int MIN_SIZE     = 3;
  localparam int DIVISOR      = 9;

  // 3x3 window
  localparam int KERNEL_DIM = 3;
  localparam int NUM_TAPS   = KERNEL_DIM * KERNEL_DIM;

  // window queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COLUMN_BITS-1:0] column;
    logic [ROW_BITS-1:0]    row;
    logic                   last_of_frame;
  } coord_t;

  typedef struct packed {
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } q_status_t;

  function automatic int max_of(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> src/w3c_pixel_if.sv
interface w3c_pixel_if import w3c_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

>>> src/w3c_result_if.sv
interface w3c_result_if import w3c_pkg::*;;
  logic                            valid;
  logic                            ready;
  logic signed [FILTERED_BITS-1:0] filtered;
  logic [COLUMN_BITS-1:0]          column;
  logic [ROW_BITS-1:0]             row;
  logic                            last_of_frame;

  modport source (output valid, output filtered, output column, output row,
                  output last_of_frame, input ready);
  modport sink   (input valid, input filtered, input column, input row,
                  input last_of_frame, output ready);
endinterface

>>> src/w3c_front.sv
module w3c_front import w3c_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  w3c_pixel_if.sink                                        in_pix,
  input  logic [WIDTH_REG_BITS-1:0]                        frame_width,
  input  logic [HEIGHT_REG_BITS-1:0]                       frame_height,
  input  q_status_t                                        q_status,
  output logic                                             push,
  output logic [NUM_TAPS*PIXEL_BITS+$bits(coord_t)-1:0]    push_data
);

  localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WB = $clog2(MAX_WIDTH + 1);

  logic [CB-1:0]              col_r;
  logic [ROW_BITS-1:0]        row_r;
  logic [WB-1:0]              w_eff;
  logic [HEIGHT_REG_BITS-1:0] h_eff;
  logic                       fire;
  logic                       col_wrap;
  logic                       row_wrap;
  logic                       emit;
  logic                       last;
  coord_t                     coord;

  // line stores: upper row in the high half, lower row in the low half
  logic [2*PIXEL_BITS-1:0]    line_mem [MAX_WIDTH];
  logic [2*PIXEL_BITS-1:0]    rd_r;

  logic                       s1_valid_r;
  logic                       s1_emit_r;
  logic [CB-1:0]              s1_slot_r;
  logic signed [PIXEL_BITS-1:0] s1_pix_r;
  coord_t                     s1_coord_r;

  // win_r[0] holds column c-2, win_r[1] column c-1, rows top to bottom
  logic [1:0][KERNEL_DIM-1:0][PIXEL_BITS-1:0] win_r;
  logic [KERNEL_DIM-1:0][PIXEL_BITS-1:0]      cur;
  logic [KERNEL_DIM-1:0][KERNEL_DIM-1:0][PIXEL_BITS-1:0] taps;

  always_comb begin
    if (32'(frame_width) < MIN_SIZE) begin
      w_eff = WB'(MIN_SIZE);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(frame_width);
    end
    if (32'(frame_height) < MIN_SIZE) begin
      h_eff = HEIGHT_REG_BITS'(MIN_SIZE);
    end else if (32'(frame_height) > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_REG_BITS'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height;
    end
  end

  // room for this beat and the one still in the read stage
  assign in_pix.ready = (32'(q_status.count) + ((s1_valid_r && s1_emit_r) ? 1 : 0))
                        < QUEUE_DEPTH;
  assign fire = in_pix.valid && in_pix.ready;

  assign col_wrap = 32'(col_r) + 1 >= 32'(w_eff);
  assign row_wrap = 32'(row_r) + 1 >= 32'(h_eff);
  assign emit = (32'(col_r) >= 2) && (32'(row_r) >= 2) &&
                (32'(col_r) < 32'(w_eff)) && (32'(row_r) < 32'(h_eff));
  assign last = (32'(col_r) + 1 == 32'(w_eff)) && (32'(row_r) + 1 == 32'(h_eff));

  always_comb begin
    coord.column        = COLUMN_BITS'(32'(col_r) - 1);
    coord.row           = ROW_BITS'(32'(row_r) - 1);
    coord.last_of_frame = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      win_r      <= '0;
    end else begin
      s1_valid_r <= fire;
      if (fire) begin
        s1_emit_r <= emit;
        if (col_wrap) begin
          col_r <= '0;
          row_r <= row_wrap ? '0 : row_r + ROW_BITS'(1);
        end else begin
          col_r <= col_r + CB'(1);
        end
      end
      if (s1_valid_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_slot_r  <= col_r;
      s1_pix_r   <= in_pix.pixel;
      s1_coord_r <= coord;
    end
  end

  // read at accept, write back in the cycle after; the same slot comes back
  // no sooner than three beats on
  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r <= line_mem[col_r];
    end
    if (s1_valid_r) begin
      line_mem[s1_slot_r] <= {rd_r[PIXEL_BITS-1:0], s1_pix_r};
    end
  end

  always_comb begin
    cur[0] = rd_r[2*PIXEL_BITS-1:PIXEL_BITS];
    cur[1] = rd_r[PIXEL_BITS-1:0];
    cur[2] = s1_pix_r;
    for (int i = 0; i < KERNEL_DIM; i++) begin
      taps[i][0] = win_r[0][i];
      taps[i][1] = win_r[1][i];
      taps[i][2] = cur[i];
    end
  end

  assign push      = s1_valid_r && s1_emit_r;
  assign push_data = {s1_coord_r, taps};

endmodule

>>> src/w3c_queue.sv
module w3c_queue import w3c_pkg::*; #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] head_data,
  output q_status_t            status
);

  logic [DATA_BITS-1:0] slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data    = slot_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.count = count_r;

endmodule

>>> src/w3c_back.sv
module w3c_back import w3c_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic [NUM_TAPS*PIXEL_BITS+$bits(coord_t)-1:0]       head_data,
  input  q_status_t                                           q_status,
  input  logic [KERNEL_DIM-1:0][KERNEL_DIM-1:0][COEF_BITS-1:0] kernel,
  output logic                                                pop,
  w3c_result_if.source                                        out_res
);

  localparam int PB         = PIXEL_BITS + COEF_BITS;
  localparam int SUM_BITS   = PB + 3;
  localparam int ABS_BITS   = PB + 2;
  localparam int SHIFT      = ABS_BITS + 4;
  localparam int RECIP_BITS = SHIFT - 3;
  localparam int MUL_BITS   = ABS_BITS + RECIP_BITS;
  localparam int Q_BITS     = PB - 1;
  localparam int CMP_BITS   = max_of(Q_BITS + 1, FILTERED_BITS) + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
  localparam logic signed [CMP_BITS-1:0] OUT_MAX =
    CMP_BITS'((64'sd1 <<< (FILTERED_BITS - 1)) - 64'sd1);
  localparam logic signed [CMP_BITS-1:0] OUT_MIN =
    CMP_BITS'(-(64'sd1 <<< (FILTERED_BITS - 1)));

  function automatic logic signed [PB-1:0] mul_w(input logic signed [PIXEL_BITS-1:0] p,
                                                 input logic signed [COEF_BITS-1:0] k);
    logic signed [PB-1:0] pe;
    logic signed [PB-1:0] ke;
    pe = PB'(p);
    ke = PB'(k);
    return pe * ke;
  endfunction

  coord_t h_coord;
  logic [KERNEL_DIM-1:0][KERNEL_DIM-1:0][PIXEL_BITS-1:0] h_taps;
  logic en;

  logic m_valid_r, a_valid_r, s_valid_r, ab_valid_r, mq_valid_r, out_valid_r;
  coord_t m_coord_r, a_coord_r, s_coord_r, ab_coord_r, mq_coord_r, out_coord_r;

  logic signed [PB-1:0]       prod_r [KERNEL_DIM][KERNEL_DIM];
  logic signed [SUM_BITS-1:0] row_sum_r [KERNEL_DIM];
  logic signed [SUM_BITS-1:0] sum_r;
  logic                       ab_neg_r;
  logic [ABS_BITS-1:0]        abs_r;
  logic                       mq_neg_r;
  logic [MUL_BITS-1:0]        mq_r;
  logic signed [FILTERED_BITS-1:0] out_filt_r;

  logic [Q_BITS-1:0]          quot;
  logic signed [CMP_BITS-1:0] quot_s;
  logic signed [CMP_BITS-1:0] signed_q;
  logic signed [CMP_BITS-1:0] clamped;

  assign {h_coord, h_taps} = head_data;
  assign en  = !out_valid_r || out_res.ready;
  assign pop = en && !q_status.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      a_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      ab_valid_r  <= 1'b0;
      mq_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r   <= pop;
      a_valid_r   <= m_valid_r;
      s_valid_r   <= a_valid_r;
      ab_valid_r  <= s_valid_r;
      mq_valid_r  <= ab_valid_r;
      out_valid_r <= mq_valid_r;
    end
  end

  // quotient magnitude from the reciprocal product, sign and clamp
  always_comb begin
    quot     = mq_r[SHIFT +: Q_BITS];
    quot_s   = signed'(CMP_BITS'(quot));
    signed_q = mq_neg_r ? -quot_s : quot_s;
    if (signed_q > OUT_MAX) begin
      clamped = OUT_MAX;
    end else if (signed_q < OUT_MIN) begin
      clamped = OUT_MIN;
    end else begin
      clamped = signed_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_coord_r <= h_coord;
      for (int i = 0; i < KERNEL_DIM; i++) begin
        for (int j = 0; j < KERNEL_DIM; j++) begin
          prod_r[i][j] <= mul_w(h_taps[i][j], kernel[i][j]);
        end
      end

      a_coord_r <= m_coord_r;
      for (int i = 0; i < KERNEL_DIM; i++) begin
        row_sum_r[i] <= SUM_BITS'(prod_r[i][0]) + SUM_BITS'(prod_r[i][1]) +
                        SUM_BITS'(prod_r[i][2]);
      end

      s_coord_r <= a_coord_r;
      sum_r     <= row_sum_r[0] + row_sum_r[1] + row_sum_r[2];

      ab_coord_r <= s_coord_r;
      ab_neg_r   <= sum_r[SUM_BITS-1];
      abs_r      <= sum_r[SUM_BITS-1] ? ABS_BITS'(-sum_r) : ABS_BITS'(sum_r);

      mq_coord_r <= ab_coord_r;
      mq_neg_r   <= ab_neg_r;
      mq_r       <= MUL_BITS'(abs_r) * MUL_BITS'(RECIP);

      out_coord_r <= mq_coord_r;
      out_filt_r  <= FILTERED_BITS'(clamped);
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.filtered      = out_filt_r;
  assign out_res.column        = out_coord_r.column;
  assign out_res.row           = out_coord_r.row;
  assign out_res.last_of_frame = out_coord_r.last_of_frame;

endmodule

>>> src/window_3x3_convolution.sv
// 3x3 convolution over a raster-order stream of signed pixels. One pixel
// beat at most is taken per clock; for every interior center pixel (not
// first or last row or column) one result beat comes out with the
// kernel-weighted sum divided by 9 (truncated toward zero, +2^22 saturates),
// the center's column and row, and a flag on the frame's last interior pixel.
// Border pixels give no result. Sustained rate is one beat per clock in and
// out while the output is ready; a beat passes the line store read stage, the
// window queue and the six-stage multiply, sum and divide pipeline. The input
// keeps flowing while a result waits until the four-entry window queue fills.
// Line stores are not cleared after reset; the first two rows of a frame
// fill them. Frame size and kernel are written through the cfg port while
// the block is idle (a user's rule, unchecked): index 0 width, 1 height,
// 2..4 kernel rows top to bottom with the left weight in the low bits.
// Out-of-range sizes are clamped to 3..MAX_WIDTH and 3..4096.
module window_3x3_convolution import w3c_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  w3c_pixel_if.sink                                         in_pix,
  w3c_result_if.source                                      out_res,
  input  logic                                              cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]                         cfg_index,
  input  logic [max_of(KERNEL_DIM*COEF_BITS, HEIGHT_REG_BITS)-1:0] cfg_data
);

  localparam int ITEM_BITS = NUM_TAPS * PIXEL_BITS + $bits(coord_t);

  // configuration registers
  logic [WIDTH_REG_BITS-1:0]  frame_width_r;
  logic [HEIGHT_REG_BITS-1:0] frame_height_r;
  logic [KERNEL_DIM-1:0][KERNEL_DIM-1:0][COEF_BITS-1:0] kernel_r;

  // front to queue to back
  logic                 q_push;
  logic [ITEM_BITS-1:0] q_push_data;
  logic                 q_pop;
  logic [ITEM_BITS-1:0] q_head;
  q_status_t            q_status;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_REG_BITS'(WIDTH_RESET);
      frame_height_r <= HEIGHT_REG_BITS'(HEIGHT_RESET);
      kernel_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   frame_width_r  <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height_r <= cfg_data[HEIGHT_REG_BITS-1:0];
        REG_KERNEL_TOP:    kernel_r[0]    <= cfg_data[KERNEL_DIM*COEF_BITS-1:0];
        REG_KERNEL_MIDDLE: kernel_r[1]    <= cfg_data[KERNEL_DIM*COEF_BITS-1:0];
        REG_KERNEL_BOTTOM: kernel_r[2]    <= cfg_data[KERNEL_DIM*COEF_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: counts columns and rows, runs the line stores and the window,
  // and pushes a full window for every interior center
  w3c_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_pix       (in_pix),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .q_status     (q_status),
    .push         (q_push),
    .push_data    (q_push_data)
  );

  // short window queue decoupling the two halves
  w3c_queue #(
    .DATA_BITS (ITEM_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .status    (q_status)
  );

  // back: multiply, sum, divide by nine, clamp, output register
  w3c_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_data (q_head),
    .q_status  (q_status),
    .kernel    (kernel_r),
    .pop       (q_pop),
    .out_res   (out_res)
  );

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_status.count) <= QUEUE_DEPTH)
    else $error("window queue overflow");

  // back only pops a filled queue
  a_pop_filled: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("pop from empty window queue");

  // an input beat is only taken while the queue has room
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |-> (32'(q_status.count) < QUEUE_DEPTH))
    else $error("input beat accepted with full window queue");

  // every window pushed comes from a beat accepted the cycle before
  a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> $past(in_pix.valid && in_pix.ready))
    else $error("window pushed without an input beat");

endmodule

>>> bench/tb_window_3x3_convolution.sv
module tb_window_3x3_convolution;
  import w3c_pkg::*;

  // cfg port width matches the block's port
  localparam int CFG_DATA_BITS = max_of(KERNEL_DIM * COEF_BITS_DEF, HEIGHT_REG_BITS);
  localparam int PX_BITS = PIXEL_BITS_DEF;
  localparam int KROW_BITS = KERNEL_DIM * COEF_BITS_DEF;

  localparam logic signed [PX_BITS-1:0] PIX_MIN = PX_BITS'(-(2 ** (PX_BITS - 1)));
  localparam logic signed [PX_BITS-1:0] PIX_MAX = PX_BITS'(2 ** (PX_BITS - 1) - 1);
  localparam longint FILT_MAX = (longint'(1) <<< (FILTERED_BITS - 1)) - 1;
  localparam longint FILT_MIN = -(longint'(1) <<< (FILTERED_BITS - 1));

  // kernel rows with every weight at one extreme
  localparam logic [KROW_BITS-1:0] KROW_ALL_MIN = 24'h808080;
  localparam logic [KROW_BITS-1:0] KROW_ALL_MAX = 24'h7F7F7F;

  // first index past the register file, writes there are dropped
  localparam logic [CFG_INDEX_BITS-1:0] NO_SUCH_REG = 3'd5;

  // margin for the pipeline to empty before touching config
  localparam int SETTLE_CYCLES = 16;
  localparam int END_WAIT_CYCLES = 2000;
  localparam int RANDOM_ITEMS = 350;
  localparam int MAX_REPORTS = 40;
  localparam longint TIMEOUT_TIME = 8_000_000;

  typedef struct {
    logic signed [FILTERED_BITS-1:0] filtered;
    logic [COLUMN_BITS-1:0]          column;
    logic [ROW_BITS-1:0]             row;
    logic                            last_of_frame;
  } filtered_pixel_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  w3c_pixel_if #(.PIXEL_BITS(PX_BITS)) pix_if ();
  w3c_result_if res_if ();

  window_3x3_convolution #(
    .MAX_WIDTH (MAX_WIDTH_DEF),
    .PIXEL_BITS(PX_BITS),
    .COEF_BITS (COEF_BITS_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (pix_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow of the block: registers, line stores, window, raster position
  logic [WIDTH_REG_BITS-1:0]  width_reg;
  logic [HEIGHT_REG_BITS-1:0] height_reg;
  logic [KROW_BITS-1:0]       kernel_rows [KERNEL_DIM];
  logic signed [PX_BITS-1:0]  upper_px [MAX_WIDTH_DEF];
  logic signed [PX_BITS-1:0]  lower_px [MAX_WIDTH_DEF];
  logic signed [PX_BITS-1:0]  window_px [2 * KERNEL_DIM];
  int unsigned col_cnt;
  int unsigned row_cnt;

  filtered_pixel_t filtered_queue [$];

  // idle knobs, flipped per phase
  bit sender_idles;
  bit receiver_idles;

  int pixels_sent;
  int results_checked;
  int size_settings;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_TIME);
    $display("timeout: %0d filtered beats still outstanding", filtered_queue.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // clamped frame size as the block applies it
  function automatic int unsigned frame_cols();
    if (width_reg < MIN_SIZE) return MIN_SIZE;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned frame_rows();
    if (height_reg < MIN_SIZE) return MIN_SIZE;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return 32'(height_reg);
  endfunction

  // signed weight, kcol 0 is the left column in the low byte
  function automatic longint weight_of(input int krow, input int kcol);
    logic signed [COEF_BITS_DEF-1:0] wt;
    wt = kernel_rows[krow][kcol * COEF_BITS_DEF +: COEF_BITS_DEF];
    return longint'(wt);
  endfunction

  // advance the shadow by one pixel, queue the filtered value if the
  // window around (c-1, r-1) is now complete
  function automatic void convolve_pixel(input logic signed [PX_BITS-1:0] px);
    int unsigned cols;
    int unsigned rows;
    int unsigned c;
    int unsigned r;
    int unsigned slot;
    int k;
    logic signed [PX_BITS-1:0] column_px [KERNEL_DIM];
    longint acc;
    longint quot;
    filtered_pixel_t res;
    cols = frame_cols();
    rows = frame_rows();
    c = col_cnt;
    r = row_cnt;
    slot = (c < MAX_WIDTH_DEF) ? c : MAX_WIDTH_DEF - 1;
    // newest column of the window: two rows up, one row up, this pixel
    column_px[0] = upper_px[slot];
    column_px[1] = lower_px[slot];
    column_px[2] = px;
    upper_px[slot] = column_px[1];
    lower_px[slot] = px;
    if (c >= 2 && r >= 2 && c < cols && r < rows) begin
      acc = 0;
      for (k = 0; k < KERNEL_DIM; k++) begin
        acc += longint'(window_px[k]) * weight_of(k, 0)
             + longint'(window_px[KERNEL_DIM + k]) * weight_of(k, 1)
             + longint'(column_px[k]) * weight_of(k, 2);
      end
      // signed divide truncates toward zero; only +2^22 can overflow
      quot = acc / DIVISOR;
      if (quot > FILT_MAX) quot = FILT_MAX;
      if (quot < FILT_MIN) quot = FILT_MIN;
      res.filtered = quot[FILTERED_BITS-1:0];
      res.column = COLUMN_BITS'(c - 1);
      res.row = ROW_BITS'(r - 1);
      res.last_of_frame = (c == cols - 1) && (r == rows - 1);
      filtered_queue.insert(filtered_queue.size(), res);
    end
    for (k = 0; k < KERNEL_DIM; k++) begin
      window_px[k] = window_px[KERNEL_DIM + k];
      window_px[KERNEL_DIM + k] = column_px[k];
    end
    // counters at or past a freshly shrunk bound wrap here too
    if (c + 1 >= cols) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // pixel stimulus: extremes, values near zero, anything
  function automatic logic signed [PX_BITS-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0: return PIX_MIN;
      1: return PIX_MAX;
      2, 3: return PX_BITS'($signed($urandom_range(0, 64)) - 32);
      default: return PX_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [KROW_BITS-1:0] random_kernel_row();
    case ($urandom_range(0, 5))
      0: return KROW_ALL_MIN;
      1: return KROW_ALL_MAX;
      2: return {8'($urandom_range(0, 6) - 3), 8'($urandom_range(0, 6) - 3),
                 8'($urandom_range(0, 6) - 3)};
      default: return KROW_BITS'($urandom);
    endcase
  endfunction

  // one cfg write, shadow updated at the write edge
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = value[WIDTH_REG_BITS-1:0];
        size_settings++;
      end
      REG_FRAME_HEIGHT:  height_reg = value[HEIGHT_REG_BITS-1:0];
      REG_KERNEL_TOP:    kernel_rows[0] = value[KROW_BITS-1:0];
      REG_KERNEL_MIDDLE: kernel_rows[1] = value[KROW_BITS-1:0];
      REG_KERNEL_BOTTOM: kernel_rows[2] = value[KROW_BITS-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_kernel(input logic [KROW_BITS-1:0] top_row,
                             input logic [KROW_BITS-1:0] mid_row,
                             input logic [KROW_BITS-1:0] bot_row);
    write_reg(REG_KERNEL_TOP, top_row);
    write_reg(REG_KERNEL_MIDDLE, mid_row);
    write_reg(REG_KERNEL_BOTTOM, bot_row);
  endtask

  // one pixel beat; valid stays up afterwards unless a gap is drawn next time
  task automatic send_pixel(input logic signed [PX_BITS-1:0] px);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk); while (!pix_if.ready);
    convolve_pixel(px);
    pixels_sent++;
  endtask

  // stop sending, let every filtered beat come out, then let the pipe empty
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (filtered_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frames(input int count);
    repeat (count * frame_cols() * frame_rows()) send_pixel(random_pixel());
  endtask

  // run out the current frame so the next one starts at column 0, row 0
  task automatic finish_frame();
    while (col_cnt != 0 || row_cnt != 0) send_pixel(random_pixel());
  endtask

  // result side: ready drops in random bursts when enabled
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (receiver_idles && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // every accepted result beat against the oldest queued one
  always @(posedge clk) begin : check_results
    filtered_pixel_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      results_checked++;
      if (filtered_queue.size() == 0) begin
        report_mismatch($sformatf("result beat at (%0d,%0d) with nothing pending",
                                  res_if.column, res_if.row));
      end else begin
        want = filtered_queue.pop_front();
        if (res_if.filtered !== want.filtered)
          report_mismatch($sformatf("filtered at (%0d,%0d): got %0d, want %0d",
                                    want.column, want.row, res_if.filtered, want.filtered));
        if (res_if.column !== want.column || res_if.row !== want.row)
          report_mismatch($sformatf("position: got (%0d,%0d), want (%0d,%0d)",
                                    res_if.column, res_if.row, want.column, want.row));
        if (res_if.last_of_frame !== want.last_of_frame)
          report_mismatch($sformatf("last_of_frame at (%0d,%0d): got %b, want %b",
                                    want.column, want.row, res_if.last_of_frame,
                                    want.last_of_frame));
      end
    end
  end

  // 3x3 frames: saturation, a negative sum from minimum pixels, pixel and weight extremes
  task automatic test_directed();
    logic signed [PX_BITS-1:0] edge_px [9];
    edge_px = '{PIX_MAX, PIX_MIN, 16'sd0, -16'sd1, 16'sd1, PIX_MAX, PIX_MIN, 16'sd21845,
                -16'sd21846};
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(MIN_SIZE));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(MIN_SIZE));
    // -32768 against -128 everywhere hits +2^22 and saturates
    load_kernel(KROW_ALL_MIN, KROW_ALL_MIN, KROW_ALL_MIN);
    repeat (9) send_pixel(PIX_MIN);
    wait_idle();
    // -32768 against +127 everywhere gives a negative quotient
    load_kernel(KROW_ALL_MAX, KROW_ALL_MAX, KROW_ALL_MAX);
    repeat (9) send_pixel(PIX_MIN);
    wait_idle();
    // mixed signs, negative remainders exercise truncation toward zero
    load_kernel(24'h7F0180, 24'h00FF01, 24'h807FFF);
    foreach (edge_px[i]) send_pixel(edge_px[i]);
    wait_idle();
  endtask

  // out-of-range sizes, upper cfg bits set to check masking
  task automatic test_size_clamps();
    write_reg(REG_FRAME_WIDTH, 24'hFFF800);
    write_reg(REG_FRAME_HEIGHT, 24'hFFE001);
    load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
    send_frames(2);
    wait_idle();
    // width above MAX_WIDTH clamps to the widest row; a row and a bit, then
    // a narrow width wraps the column into row 2 where results show the row
    write_reg(REG_FRAME_WIDTH, 24'h0007FF);
    write_reg(REG_FRAME_HEIGHT, 24'h000002);
    repeat (MAX_WIDTH_DEF + 6) send_pixel(random_pixel());
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(5));
    finish_frame();
    wait_idle();
  endtask

  task automatic test_ignored_index();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(5));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(4));
    load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
    for (int k = 0; k < 3; k++)
      write_reg(CFG_INDEX_BITS'(NO_SUCH_REG + k), CFG_DATA_BITS'($urandom));
    send_frames(2);
    wait_idle();
  endtask

  // size changes in the middle of a frame take effect at once
  task automatic test_mid_frame_resize();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(12));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(6));
    load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
    repeat (3 * 12 + 5) send_pixel(random_pixel());
    wait_idle();
    // both counters now sit past the new bounds and must wrap
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(4));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(3));
    finish_frame();
    send_frames(2);
    // taller frame while in row 1, no wrap involved
    repeat (5) send_pixel(random_pixel());
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'(7));
    finish_frame();
    wait_idle();
  endtask

  // small random frames and kernels, back to back frames per setting
  task automatic test_random_frames();
    int start_count;
    int phase;
    int n_frames;
    int frame_px;
    start_count = pixels_sent;
    phase = 0;
    while (pixels_sent - start_count < RANDOM_ITEMS) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      write_reg(REG_FRAME_WIDTH,
                CFG_DATA_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                           : $urandom_range(3, 16)));
      write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'($urandom_range(3, 8)));
      load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
      n_frames = $urandom_range(1, 3);
      frame_px = frame_cols() * frame_rows();
      for (int f = 0; f < n_frames; f++) begin
        for (int n = 0; n < frame_px; n++) begin
          // hold the sender mid-frame until the output side has caught up
          if (f == 0 && n == frame_px / 2 && (phase == 0 || $urandom_range(0, 3) == 0))
            wait_idle();
          send_pixel(random_pixel());
        end
      end
      wait_idle();
      phase++;
    end
  endtask

  // height above the limit clamps to 4096, first rows at full rate
  task automatic test_tall_frame();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'(MIN_SIZE));
    write_reg(REG_FRAME_HEIGHT, 24'h001FFF);
    load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
    repeat (8 * frame_cols()) send_pixel(random_pixel());
  endtask

  initial begin
    int waited;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= '0;
    pix_if.valid <= 1'b0;
    pix_if.pixel <= '0;
    // shadow starts from the reset values
    width_reg = WIDTH_REG_BITS'(WIDTH_RESET);
    height_reg = HEIGHT_REG_BITS'(HEIGHT_RESET);
    foreach (kernel_rows[i]) kernel_rows[i] = '0;
    foreach (upper_px[i]) upper_px[i] = '0;
    foreach (lower_px[i]) lower_px[i] = '0;
    foreach (window_px[i]) window_px[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    pixels_sent = 0;
    results_checked = 0;
    size_settings = 0;
    mismatches = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_size_clamps();
    test_ignored_index();
    test_mid_frame_resize();
    test_random_frames();
    test_tall_frame();

    // drain, then give stray beats a chance to show up
    pix_if.valid <= 1'b0;
    waited = 0;
    while (filtered_queue.size() != 0 && waited < END_WAIT_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (filtered_queue.size() != 0)
      report_mismatch($sformatf("%0d filtered beats never arrived", filtered_queue.size()));

    $display("%0d pixel beats in, %0d result beats checked over %0d frame width settings",
             pixels_sent, results_checked, size_settings);
    $display("saturation, size clamps, mid-frame resize, dropped indexes, over-tall frame");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
